/* sv/emm_pkg.sv */
package emm_pkg;

  // Angle units: degrees times 64
  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int HALF_TURN    = 11520;
  localparam int TRI_QUARTER  = 17280;

  // Radians per angle unit, Q40
  localparam logic [28:0] RAD_Q40 = 29'd299845282;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Taylor divisors 110, 72, 42, 20, 6 as reciprocal multiply: q = (x * M) >> K,
  // exact for any 32-bit x.
  localparam int TAYLOR_TERMS = 5;
  localparam int DIV_K [TAYLOR_TERMS] = '{39, 39, 38, 37, 35};
  localparam logic [32:0] DIV_M [TAYLOR_TERMS] = '{
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };

  // Pipeline layout
  localparam int TRIG_STAGES = 6 + 2 * TAYLOR_TERMS;
  localparam int MAT_STAGES  = 4;
  localparam int MAT_BASE    = TRIG_STAGES;
  localparam int OUT_STAGE   = TRIG_STAGES + MAT_STAGES;
  localparam int NUM_STAGES  = OUT_STAGE + 1;

  typedef logic signed [17:0] trig_t;  // Q16 sine or cosine
  typedef logic signed [23:0] ent_t;   // Q8.16 entry or scale

  typedef struct packed {
    logic [95:0] pos;    // pos_z, pos_y, pos_x
    logic [71:0] scale;  // scale_z, scale_y, scale_x
  } carry_t;

endpackage

/* sv/emm_trig.sv */
module emm_trig (
  input  logic                             clk,
  input  logic [emm_pkg::TRIG_STAGES-1:0]  en,
  input  logic signed [15:0]               angle,
  output emm_pkg::trig_t                   sin_q,
  output emm_pkg::trig_t                   cos_q
);
  import emm_pkg::*;

  logic signed [17:0] w;
  logic [14:0]        a_nxt;
  logic [14:0]        a_r;
  trig_t              res_r [2];

  // modulo 360 degrees
  always_comb begin
    w = 18'(angle);
    if (w < 0) w = w + 18'(FULL_TURN);
    if (w < 0) w = w + 18'(FULL_TURN);
    if (w >= 18'(FULL_TURN)) w = w - 18'(FULL_TURN);
    a_nxt = w[14:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) a_r <= a_nxt;
  end

  // lane 0 sine, lane 1 cosine (sine of angle plus a quarter turn)
  for (genvar L = 0; L < 2; L++) begin : g_lane
    logic [15:0] b;
    logic [1:0]  quad;
    logic [12:0] rr;
    logic [12:0] r_nxt;
    logic [12:0] r_r;
    logic [41:0] th_full;
    logic [61:0] sq;
    logic [61:0] sp;
    logic [30:0] s_r;
    logic [16:0] mag;
    logic        neg_r   [1:14];
    logic [30:0] theta_r [2:13];
    logic [31:0] t2_r    [3:11];
    logic [31:0] x_nxt   [TAYLOR_TERMS];
    logic [31:0] x_r     [TAYLOR_TERMS];
    logic [30:0] p_nxt   [TAYLOR_TERMS];
    logic [30:0] p_r     [TAYLOR_TERMS];

    always_comb begin
      b = 16'(a_r) + ((L == 1) ? 16'(QUARTER_TURN) : 16'd0);
      if (b >= 16'(FULL_TURN)) b = b - 16'(FULL_TURN);
      if (b >= 16'(TRI_QUARTER)) begin
        quad = 2'd3;
        rr   = 13'(b - 16'(TRI_QUARTER));
      end else if (b >= 16'(HALF_TURN)) begin
        quad = 2'd2;
        rr   = 13'(b - 16'(HALF_TURN));
      end else if (b >= 16'(QUARTER_TURN)) begin
        quad = 2'd1;
        rr   = 13'(b - 16'(QUARTER_TURN));
      end else begin
        quad = 2'd0;
        rr   = 13'(b);
      end
      r_nxt = quad[0] ? 13'(QUARTER_TURN) - rr : rr;
    end

    assign th_full = 42'(r_r) * 42'(RAD_Q40) + 42'd512;
    assign sq      = 62'(theta_r[2]) * 62'(theta_r[2]);

    // one Taylor term per two stages: multiply by t2, then divide by constant
    for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_it
      logic [30:0] pin;
      logic [62:0] xp;
      logic [65:0] qp;
      logic [31:0] q;
      if (i == 0) begin : g_first
        assign pin = ONE_Q30;
      end else begin : g_next
        assign pin = p_r[i-1];
      end
      assign xp       = 63'(t2_r[3+2*i]) * 63'(pin);
      assign x_nxt[i] = xp[61:30];
      assign qp       = 66'(x_r[i]) * 66'(DIV_M[i]);
      assign q        = 32'(qp >> DIV_K[i]);
      assign p_nxt[i] = ONE_Q30 - q[30:0];
    end

    assign sp  = 62'(theta_r[13]) * 62'(p_r[TAYLOR_TERMS-1]);
    assign mag = 17'((32'(s_r) + 32'd8192) >> 14);

    always_ff @(posedge clk) begin
      if (en[1]) begin
        r_r      <= r_nxt;
        neg_r[1] <= quad[1];
      end
      if (en[2]) begin
        theta_r[2] <= th_full[40:10];
        neg_r[2]   <= neg_r[1];
      end
      if (en[3]) begin
        t2_r[3]    <= sq[61:30];
        theta_r[3] <= theta_r[2];
        neg_r[3]   <= neg_r[2];
      end
      for (int s = 4; s <= 13; s++) begin
        if (en[s]) begin
          theta_r[s] <= theta_r[s-1];
          neg_r[s]   <= neg_r[s-1];
        end
      end
      for (int s = 4; s <= 11; s++) begin
        if (en[s]) t2_r[s] <= t2_r[s-1];
      end
      for (int i = 0; i < TAYLOR_TERMS; i++) begin
        if (en[4+2*i]) x_r[i] <= x_nxt[i];
        if (en[5+2*i]) p_r[i] <= p_nxt[i];
      end
      if (en[14]) begin
        s_r       <= sp[60:30];
        neg_r[14] <= neg_r[13];
      end
      if (en[15]) res_r[L] <= neg_r[14] ? -trig_t'(mag) : trig_t'(mag);
    end
  end

  assign sin_q = res_r[0];
  assign cos_q = res_r[1];

endmodule

/* sv/emm_mat.sv */
module emm_mat (
  input  logic                            clk,
  input  logic [emm_pkg::MAT_STAGES-1:0]  en,
  input  emm_pkg::trig_t                  sp,
  input  emm_pkg::trig_t                  cp,
  input  emm_pkg::trig_t                  sy,
  input  emm_pkg::trig_t                  cy,
  input  emm_pkg::trig_t                  sr,
  input  emm_pkg::trig_t                  cr,
  input  emm_pkg::ent_t                   scale [3],
  output emm_pkg::ent_t                   ent   [9]
);
  import emm_pkg::*;

  // stage 0: two-factor products
  logic signed [35:0] cycr_r, sysp_r, cpsr_r, cpcr_r, cysp_r;
  logic signed [35:0] sycr_r, sysr_r, sycp_r, cysr_r, cycp_r;
  trig_t              sp_r, sr_r, cr_r;
  // stage 1: three-factor products plus carried terms
  logic signed [53:0] syspsr_r, syspcr_r, cyspsr_r, cyspcr_r;
  logic signed [35:0] cycr1_r, cpsr1_r, cpcr1_r, sycr1_r, sysr1_r;
  logic signed [35:0] sycp1_r, cysr1_r, cycp1_r;
  trig_t              sp1_r;
  // stage 2: rotation rounded to Q30, column-major
  logic signed [33:0] r30_r  [9];
  // stage 3: times scale
  logic signed [57:0] prod_r [9];
  logic signed [57:0] rnd    [9];

  function automatic logic signed [53:0] sh16(input logic signed [35:0] v);
    sh16 = 54'(v) <<< 16;
  endfunction

  function automatic logic signed [33:0] rnd18(input logic signed [53:0] v);
    logic signed [53:0] t;
    t = v + 54'sd131072;
    rnd18 = 34'(t >>> 18);
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cycr_r <= 36'(cy) * 36'(cr);
      sysp_r <= 36'(sy) * 36'(sp);
      cpsr_r <= 36'(cp) * 36'(sr);
      cpcr_r <= 36'(cp) * 36'(cr);
      cysp_r <= 36'(cy) * 36'(sp);
      sycr_r <= 36'(sy) * 36'(cr);
      sysr_r <= 36'(sy) * 36'(sr);
      sycp_r <= 36'(sy) * 36'(cp);
      cysr_r <= 36'(cy) * 36'(sr);
      cycp_r <= 36'(cy) * 36'(cp);
      sp_r   <= sp;
      sr_r   <= sr;
      cr_r   <= cr;
    end
    if (en[1]) begin
      syspsr_r <= 54'(sysp_r) * 54'(sr_r);
      syspcr_r <= 54'(sysp_r) * 54'(cr_r);
      cyspsr_r <= 54'(cysp_r) * 54'(sr_r);
      cyspcr_r <= 54'(cysp_r) * 54'(cr_r);
      cycr1_r  <= cycr_r;
      cpsr1_r  <= cpsr_r;
      cpcr1_r  <= cpcr_r;
      sycr1_r  <= sycr_r;
      sysr1_r  <= sysr_r;
      sycp1_r  <= sycp_r;
      cysr1_r  <= cysr_r;
      cycp1_r  <= cycp_r;
      sp1_r    <= sp_r;
    end
    if (en[2]) begin
      r30_r[0] <= rnd18(sh16(cycr1_r) + syspsr_r);
      r30_r[1] <= rnd18(sh16(cpsr1_r));
      r30_r[2] <= rnd18(cyspsr_r - sh16(sycr1_r));
      r30_r[3] <= rnd18(syspcr_r - sh16(cysr1_r));
      r30_r[4] <= rnd18(sh16(cpcr1_r));
      r30_r[5] <= rnd18(sh16(sysr1_r) + cyspcr_r);
      r30_r[6] <= rnd18(sh16(sycp1_r));
      r30_r[7] <= rnd18(-(54'(sp1_r) <<< 32));
      r30_r[8] <= rnd18(sh16(cycp1_r));
    end
    if (en[3]) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_r[c*3+r] <= 58'(r30_r[c*3+r]) * 58'(scale[c]);
        end
      end
    end
  end

  // round to Q16 and saturate
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rnd[k] = (prod_r[k] + 58'sd536870912) >>> 30;
      if (rnd[k] > 58'sd8388607)       ent[k] = 24'sh7FFFFF;
      else if (rnd[k] < -58'sd8388608) ent[k] = 24'sh800000;
      else                             ent[k] = ent_t'(rnd[k]);
    end
  end

endmodule

/* sv/euler_model_matrix_unit.sv */
// Builds the affine model matrix M = T * Ry(yaw) * Rx(pitch) * Rz(roll) * S
// from one input beat and returns its top three rows, column-major, as one
// output beat. Angles are signed degrees times 64 and any 16-bit code is taken
// modulo 360 degrees; sine and cosine come from a fixed-point Taylor series
// with 16 fractional bits. Scale and the nine rotation-scale entries are signed
// Q8.16, the entries saturate; the position is copied untouched into column 3.
// The unit is a 21-stage pipeline: one beat per clock sustained while
// out_tready stays high, and out_tvalid rises once an accepted input beat
// has moved through all stages to the output register. Sixteen stages form the
// sine and cosine of all three angles in parallel (angle fold, quadrant, radian
// multiply, square, two stages per Taylor term, then the sine product and the
// final rounding with sign), four stages form the matrix products, and the
// last stage is the output register. Each stage has its own valid bit and
// advances when it is empty or the stage after it moves, so bubbles are
// squeezed out under back-pressure and nothing is lost.
module euler_model_matrix_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, pitch_deg, yaw_deg, roll_deg, scale_x, scale_y, scale_z
  input  logic [215:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2,
  // trans_x, trans_y, trans_z
  output logic [311:0] out_tdata
);
  import emm_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] en;
  carry_t                carry_r [OUT_STAGE];
  trig_t                 sp, cp, sy, cy, sr, cr;
  ent_t                  scl [3];
  ent_t                  ent [9];
  ent_t                  ent_r [9];
  logic [95:0]           pos_r;

  // per-stage advance: a stage moves when empty or when its successor moves
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // position and scale ride alongside the trig and matrix stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      carry_r[0].pos   <= in_tdata[95:0];
      carry_r[0].scale <= in_tdata[215:144];
    end
    for (int i = 1; i < OUT_STAGE; i++) begin
      if (en[i]) carry_r[i] <= carry_r[i-1];
    end
  end

  emm_trig u_trig_p (
    .clk   (clk),
    .en    (en[TRIG_STAGES-1:0]),
    .angle (in_tdata[111:96]),
    .sin_q (sp),
    .cos_q (cp)
  );

  emm_trig u_trig_y (
    .clk   (clk),
    .en    (en[TRIG_STAGES-1:0]),
    .angle (in_tdata[127:112]),
    .sin_q (sy),
    .cos_q (cy)
  );

  emm_trig u_trig_r (
    .clk   (clk),
    .en    (en[TRIG_STAGES-1:0]),
    .angle (in_tdata[143:128]),
    .sin_q (sr),
    .cos_q (cr)
  );

  // scale is read by the last matrix stage, so it comes from the stage before
  assign scl[0] = carry_r[OUT_STAGE-2].scale[23:0];
  assign scl[1] = carry_r[OUT_STAGE-2].scale[47:24];
  assign scl[2] = carry_r[OUT_STAGE-2].scale[71:48];

  emm_mat u_mat (
    .clk   (clk),
    .en    (en[MAT_BASE +: MAT_STAGES]),
    .sp    (sp),
    .cp    (cp),
    .sy    (sy),
    .cy    (cy),
    .sr    (sr),
    .cr    (cr),
    .scale (scl),
    .ent   (ent)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en[OUT_STAGE]) begin
      ent_r <= ent;
      pos_r <= carry_r[OUT_STAGE-1].pos;
    end
  end

  assign out_tdata = {pos_r, ent_r[8], ent_r[7], ent_r[6], ent_r[5], ent_r[4],
                      ent_r[3], ent_r[2], ent_r[1], ent_r[0]};

  // an empty first stage always takes a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_tready)
    else $error("input stalled with empty first stage");

  // an accepted beat lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted beat lost at pipeline entry");

  // a held output beat keeps its valid bit
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NUM_STAGES-1] && !out_tready |=> vld_r[NUM_STAGES-1])
    else $error("stalled output beat dropped");

  // pitch sine, yaw cosine and roll sine stay within one in Q16
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[TRIG_STAGES-1] |-> (sp <= 18'sd65536) && (sp >= -18'sd65536) &&
                             (cy <= 18'sd65536) && (cy >= -18'sd65536) &&
                             (sr <= 18'sd65536) && (sr >= -18'sd65536))
    else $error("trig value out of range");

endmodule
